>>> design/kpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpa_pkg - keypad event to ASCII shared definitions
// Key indexes, character codes and the two 4x10 layer lookup tables.
// ----------------------------------------------------------------------------
package kpa_pkg;

  localparam int unsigned KEY_COUNT = 40;

  typedef logic [6:0] kpa_char_t;
  typedef logic [5:0] kpa_idx_t;

  // Matrix indexes (key code minus one)
  localparam kpa_idx_t IDX_ENTER     = 6'd19;
  localparam kpa_idx_t IDX_SYMBOL    = 6'd20;
  localparam kpa_idx_t IDX_LETTER_B  = 6'd25;
  localparam kpa_idx_t IDX_CAPS      = 6'd28;
  localparam kpa_idx_t IDX_BACKSPACE = 6'd29;
  localparam kpa_idx_t IDX_SPACE     = 6'd30;

  localparam kpa_char_t CH_NONE  = 7'h00;
  localparam kpa_char_t CH_BS    = 7'h08;
  localparam kpa_char_t CH_CR    = 7'h0d;
  localparam kpa_char_t CH_SPACE = 7'h20;
  localparam kpa_char_t CH_UC_B  = 7'h42;
  localparam kpa_char_t CH_LC_A  = 7'h61;
  localparam kpa_char_t CH_LC_B  = 7'h62;
  localparam kpa_char_t CH_LC_Z  = 7'h7a;

  localparam kpa_char_t NORMAL_TAB [KEY_COUNT] = '{
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6f, 7'h70,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h0d,
    7'h00, 7'h7a, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6e, 7'h6d, 7'h00, 7'h00,
    7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam kpa_char_t SYMBOL_TAB [KEY_COUNT] = '{
    7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
    7'h2a, 7'h2f, 7'h2b, 7'h2d, 7'h3d, 7'h3a, 7'h27, 7'h22, 7'h40, 7'h00,
    7'h00, 7'h5f, 7'h24, 7'h3b, 7'h3f, 7'h21, 7'h2c, 7'h2e, 7'h00, 7'h00,
    7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

endpackage

>>> design/keypad_event_to_ascii_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_event_to_ascii_unit - keypad matrix event to ASCII character
// Tracks the symbol-layer and caps-lock keys and turns key presses into at
// most one ASCII character per event.
// ----------------------------------------------------------------------------
//
//  channel  | direction | tdata fields (low bit up)        | per transaction
//  ---------+-----------+----------------------------------+-----------------
//  in_      | slave     | event_byte[7:0]                  | one keypad event
//  out_     | master    | char_code[6:0], 1 zero pad bit   | zero or one char
//
//  One event is taken every clock cycle while the output is not stalled. An
//  accepted event sits in the input register until it can move on, is
//  translated by the table lookup and flag logic, and its character is then
//  loaded into the output register, which drives out_tvalid. Events that
//  give no character still pass through the input register and update the
//  flags in order. Reset (rst_n low, synchronous) clears both flags and
//  both valid bits. A stalled output holds the input register; in_tready
//  drops only when the input register is full and cannot move on.
//
module keypad_event_to_ascii_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] event_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [6:0] char_code, [7] zero
);

  import kpa_pkg::*;

  // Input register
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] ev_r, ev_nxt;

  // Flags
  logic sym_r, sym_nxt;
  logic caps_r, caps_nxt;

  // Output register
  logic      out_vld_r, out_vld_nxt;
  kpa_char_t char_r, char_nxt;

  // Translation of the held event
  logic      advance;
  logic      press;
  logic [6:0] code;
  logic      key_ok;
  kpa_idx_t  idx;
  kpa_idx_t  tab_idx;
  kpa_char_t norm_c;
  kpa_char_t sym_c;
  kpa_char_t lut_c;
  kpa_char_t res_c;

  // Move the held event on when the output register is free or being drained
  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  assign press   = ev_r[7];
  assign code    = ev_r[6:0];
  assign key_ok  = (code != 7'd0) && (code <= 7'(KEY_COUNT));
  assign idx     = 6'(code - 7'd1);
  // Keep the table index in range for codes that are dropped anyway
  assign tab_idx = key_ok ? idx : '0;
  assign norm_c  = NORMAL_TAB[tab_idx];
  assign sym_c   = SYMBOL_TAB[tab_idx];

  always_comb begin
    // Normal layer raises a..z under caps lock; symbol layer ignores it
    if (sym_r) begin
      lut_c = sym_c;
    end else if (caps_r && norm_c >= CH_LC_A && norm_c <= CH_LC_Z) begin
      lut_c = norm_c & ~7'h20;
    end else begin
      lut_c = norm_c;
    end

    if (!key_ok || !press || idx == IDX_SYMBOL || idx == IDX_CAPS) begin
      res_c = CH_NONE;
    end else if (idx == IDX_BACKSPACE) begin
      res_c = CH_BS;
    end else if (idx == IDX_LETTER_B) begin
      res_c = caps_r ? CH_UC_B : CH_LC_B;
    end else if (idx == IDX_ENTER) begin
      res_c = CH_CR;
    end else if (idx == IDX_SPACE) begin
      res_c = CH_SPACE;
    end else begin
      res_c = lut_c;
    end
  end

  always_comb begin
    in_vld_nxt  = in_vld_r;
    ev_nxt      = ev_r;
    sym_nxt     = sym_r;
    caps_nxt    = caps_r;
    out_vld_nxt = out_vld_r;
    char_nxt    = char_r;

    // Drop the delivered character
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    if (advance) begin
      in_vld_nxt = 1'b0;
      if (key_ok && idx == IDX_SYMBOL) begin
        sym_nxt = press;
      end
      if (key_ok && idx == IDX_CAPS && press) begin
        caps_nxt = !caps_r;
      end
      if (res_c != CH_NONE) begin
        out_vld_nxt = 1'b1;
        char_nxt    = res_c;
      end
    end

    // Capture a new event
    if (in_tvalid && in_tready) begin
      in_vld_nxt = 1'b1;
      ev_nxt     = in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      sym_r     <= 1'b0;
      caps_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      sym_r     <= sym_nxt;
      caps_r    <= caps_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_r   <= ev_nxt;
    char_r <= char_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, char_r};

  // Caps lock flips only when a caps press leaves the input register
  a_caps_flip : assert property (@(posedge clk) disable iff (!rst_n)
    (caps_r != $past(caps_r)) |->
      $past(advance && key_ok && idx == IDX_CAPS && press))
    else $error("caps lock changed without a caps key press");

  // Symbol flag moves only on a symbol key event
  a_sym_change : assert property (@(posedge clk) disable iff (!rst_n)
    (sym_r != $past(sym_r)) |-> $past(advance && key_ok && idx == IDX_SYMBOL))
    else $error("symbol layer changed without a symbol key event");

  // A new character comes only from an event leaving the input register
  a_out_source : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !$past(out_vld_r && !out_tready) && $past(rst_n)) |->
      $past(advance))
    else $error("output character without a translated event");

  // Every delivered character is non-empty
  a_out_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (char_r != CH_NONE))
    else $error("empty character presented on the output");

endmodule
